// File: rtl/hexp_pkg.sv
// Shared types, character codes and decode helpers of the hex text parser.
package hexp_pkg;

  // Default token store depth
  localparam int unsigned TOKEN_MAX_DEF = 64;

  // Width of one text character
  localparam int unsigned CHAR_W = 8;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Upper to lower case offset
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Digit mapping: (c mod 32 + 9) mod 25
  localparam logic [5:0] DV_BIAS = 6'd9;
  localparam logic [5:0] DV_MOD  = 6'd25;

  // Input request and result payloads
  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } hexp_in_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_status;
    logic       parse_failed;
    logic       last;
  } hexp_out_t;

  // Operations toward the result emitter
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_CLOSE,
    OP_STATUS
  } emit_op_e;

  typedef struct packed {
    emit_op_e   op;
    logic [7:0] value;
    logic       failed;
  } emit_req_t;

  // Flush walker control and status
  typedef struct packed {
    logic start;
    logic quoted;
  } walk_ctl_t;

  typedef struct packed {
    logic done;
    logic failed;
  } walk_sts_t;

  // Map one character to its digit value
  function automatic logic [4:0] digit_val(input logic [7:0] c);
    logic [5:0] s;
    s = {1'b0, c[4:0]} + DV_BIAS;
    if (s >= DV_MOD) begin
      s = s - DV_MOD;
    end
    return s[4:0];
  endfunction

  // Lowercase hex digit test
  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_LO_A) && (c <= CH_LO_F));
  endfunction

endpackage

// File: rtl/hexp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hexp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/hexp_walk.sv
// Flush walker: reads the token store and decodes plain or quoted tokens into bytes.
module hexp_walk
  import hexp_pkg::*;
#(
  parameter int unsigned TOKEN_MAX = TOKEN_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  walk_ctl_t                        ctl_i,
  input  logic [$clog2(TOKEN_MAX+1)-1:0]   base_i,
  input  logic [$clog2(TOKEN_MAX+1)-1:0]   len_i,
  output walk_sts_t                        sts_o,
  output logic                             rd_en_o,
  output logic [$clog2(TOKEN_MAX)-1:0]     rd_addr_o,
  input  logic [CHAR_W-1:0]                rd_data_i,
  output logic                             push_valid_o,
  output logic [7:0]                       push_byte_o,
  input  logic                             push_ready_i
);

  localparam int unsigned CNT_W = $clog2(TOKEN_MAX + 1);
  localparam int unsigned AW    = $clog2(TOKEN_MAX);

  localparam logic [3:0] W_IDLE    = 4'd0;
  localparam logic [3:0] W_FETCH   = 4'd1;
  localparam logic [3:0] W_USE     = 4'd2;
  localparam logic [3:0] W_QCHK    = 4'd3;
  localparam logic [3:0] W_QBS     = 4'd4;
  localparam logic [3:0] W_QX      = 4'd5;
  localparam logic [3:0] W_QDFETCH = 4'd6;
  localparam logic [3:0] W_QDUSE   = 4'd7;
  localparam logic [3:0] W_FIN     = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [4:0]       hi_q, hi_d;
  logic             hi_have_q, hi_have_d;
  logic             fail_q, fail_d;

  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] idx_p2;
  logic [CNT_W:0]   idx_ext_p2;
  logic             grp_short;
  logic             at_end;
  logic [4:0]       dv_c;
  logic [7:0]       pair_byte;
  logic [7:0]       single_byte;

  assign idx_p1      = idx_q + CNT_W'(1);
  assign idx_p2      = idx_q + CNT_W'(2);
  assign idx_ext_p2  = {1'b0, idx_q} + (CNT_W + 1)'(2);
  assign grp_short   = (idx_ext_p2 >= {1'b0, len_q});
  assign at_end      = (idx_q == len_q);
  assign dv_c        = digit_val(rd_data_i);
  assign pair_byte   = {hi_q[3:0], 4'b0000} + {3'b000, dv_c};
  assign single_byte = {3'b000, hi_q};

  // Sequence reads and decode one character per visit
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    len_d        = len_q;
    hi_d         = hi_q;
    hi_have_d    = hi_have_q;
    fail_d       = fail_q;
    rd_en_o      = 1'b0;
    rd_addr_o    = idx_q[AW-1:0];
    push_valid_o = 1'b0;
    push_byte_o  = pair_byte;
    sts_o        = '0;

    unique case (state_q)
      W_IDLE: begin
        if (ctl_i.start) begin
          idx_d  = base_i;
          len_d  = len_i;
          hi_d   = '0;
          fail_d = 1'b0;
          if (ctl_i.quoted) begin
            hi_have_d = 1'b0;
            state_d   = W_QCHK;
          end else begin
            // odd run length: first digit pairs with an implied zero
            hi_have_d = len_i[0] ^ base_i[0];
            state_d   = W_FETCH;
          end
        end
      end

      W_FETCH: begin
        if (at_end) begin
          state_d = W_FIN;
        end else begin
          rd_en_o = 1'b1;
          state_d = W_USE;
        end
      end

      W_USE: begin
        if (hi_have_q) begin
          push_valid_o = 1'b1;
          if (push_ready_i) begin
            idx_d     = idx_p1;
            hi_have_d = 1'b0;
            state_d   = W_FETCH;
          end
        end else begin
          hi_d      = dv_c;
          hi_have_d = 1'b1;
          idx_d     = idx_p1;
          state_d   = W_FETCH;
        end
      end

      // Group start: stop quietly when fewer than three characters remain
      W_QCHK: begin
        if (grp_short) begin
          state_d = W_FIN;
        end else begin
          rd_en_o = 1'b1;
          state_d = W_QBS;
        end
      end

      W_QBS: begin
        if (rd_data_i == CH_BSLASH) begin
          rd_en_o   = 1'b1;
          rd_addr_o = idx_p1[AW-1:0];
          state_d   = W_QX;
        end else begin
          fail_d  = 1'b1;
          state_d = W_FIN;
        end
      end

      W_QX: begin
        if (rd_data_i == CH_X) begin
          idx_d   = idx_p2;
          state_d = W_QDFETCH;
        end else begin
          fail_d  = 1'b1;
          state_d = W_FIN;
        end
      end

      W_QDFETCH: begin
        if (at_end) begin
          if (hi_have_q) begin
            push_valid_o = 1'b1;
            push_byte_o  = single_byte;
            if (push_ready_i) begin
              hi_have_d = 1'b0;
              state_d   = W_FIN;
            end
          end else begin
            state_d = W_FIN;
          end
        end else begin
          rd_en_o = 1'b1;
          state_d = W_QDUSE;
        end
      end

      W_QDUSE: begin
        if (is_hex(rd_data_i)) begin
          if (!hi_have_q) begin
            hi_d      = dv_c;
            hi_have_d = 1'b1;
            idx_d     = idx_p1;
            state_d   = W_QDFETCH;
          end else begin
            push_valid_o = 1'b1;
            if (push_ready_i) begin
              hi_have_d = 1'b0;
              idx_d     = idx_p1;
              state_d   = W_QCHK;
            end
          end
        end else if (rd_data_i == CH_BSLASH) begin
          // backslash ends the group early; it starts the next one
          if (hi_have_q) begin
            push_valid_o = 1'b1;
            push_byte_o  = single_byte;
            if (push_ready_i) begin
              hi_have_d = 1'b0;
              state_d   = W_QCHK;
            end
          end else begin
            state_d = W_QCHK;
          end
        end else begin
          fail_d  = 1'b1;
          state_d = W_FIN;
        end
      end

      W_FIN: begin
        sts_o.done   = 1'b1;
        sts_o.failed = fail_q;
        state_d      = W_IDLE;
      end

      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= W_IDLE;
      hi_have_q <= 1'b0;
      fail_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      hi_have_q <= hi_have_d;
      fail_q    <= fail_d;
    end
  end

  // Walk position and digit holding
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    len_q <= len_d;
    hi_q  <= hi_d;
  end

endmodule

// File: rtl/hexp_emit.sv
// Result emitter: holds one byte back to mark the last one, and drives the output register.
module hexp_emit
  import hexp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  emit_req_t req_i,
  output logic      req_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hexp_out_t out_data_o
);

  logic       pend_valid_q, pend_valid_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic       out_valid_q, out_valid_d;
  hexp_out_t  out_data_q, out_data_d;
  logic       slot_free;
  logic       out_load;

  assign slot_free = !out_valid_q || out_ready_i;

  // Move the held byte out when another result follows it
  always_comb begin
    req_ready_o  = 1'b0;
    out_load     = 1'b0;
    out_data_d   = out_data_q;
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;

    if (req_valid_i && slot_free) begin
      unique case (req_i.op)
        OP_BYTE: begin
          req_ready_o = 1'b1;
          if (pend_valid_q) begin
            out_load   = 1'b1;
            out_data_d = '{byte_value: pend_byte_q, is_status: 1'b0,
                           parse_failed: 1'b0, last: 1'b0};
          end
          pend_byte_d  = req_i.value;
          pend_valid_d = 1'b1;
        end
        OP_CLOSE: begin
          req_ready_o = 1'b1;
          if (pend_valid_q) begin
            out_load     = 1'b1;
            out_data_d   = '{byte_value: pend_byte_q, is_status: 1'b0,
                             parse_failed: 1'b0, last: 1'b1};
            pend_valid_d = 1'b0;
          end
        end
        OP_STATUS: begin
          if (pend_valid_q) begin
            // drain the held byte first, status follows next
            out_load     = 1'b1;
            out_data_d   = '{byte_value: pend_byte_q, is_status: 1'b0,
                             parse_failed: 1'b0, last: 1'b0};
            pend_valid_d = 1'b0;
          end else begin
            req_ready_o = 1'b1;
            out_load    = 1'b1;
            out_data_d  = '{byte_value: 8'h00, is_status: 1'b1,
                            parse_failed: req_i.failed, last: 1'b1};
          end
        end
        default: begin
          req_ready_o = 1'b1;
        end
      endcase
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/hex_text_to_bytes_parser_top.sv
// Top level of the hex text parser: character handling, token store, walker and emitter.
// A new request is taken every cycle while no flush, close or status is in progress.
// A flush holds the input while the walker fetches, then uses, each walked character (the
// token RAM read is registered), then finishes the walk and closes; output stalls lengthen it.
// End of text sends one status result; after a flush, the held byte is drained first.
// Reset clears quote, brace, error and fill state; the token RAM keeps its contents.
module hex_text_to_bytes_parser_top
  import hexp_pkg::*;
#(
  parameter int unsigned TOKEN_MAX = TOKEN_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hexp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hexp_out_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(TOKEN_MAX + 1);
  localparam int unsigned AW    = $clog2(TOKEN_MAX);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TOKEN_MAX);
  localparam logic [CNT_W-1:0] ZX_BASE  = CNT_W'(2);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_CLOSE  = 2'd2;
  localparam logic [1:0] S_STATUS = 2'd3;

  // Summary of the stored token, kept up to date on every append
  typedef struct packed {
    logic c0_zero;
    logic c0_dash;
    logic c1_x;
    logic x_any;
    logic x_from2;
    logic dash_from1;
    logic dash_from2;
  } tok_flags_t;

  logic [1:0]       state_q, state_d;
  logic             in_quote_q, in_quote_d;
  logic             in_braces_q, in_braces_d;
  logic             error_q, error_d;
  logic             end_q, end_d;
  logic [CNT_W-1:0] count_q, count_d;
  tok_flags_t       flags_q, flags_d, flags_next;

  logic             accept;
  logic [7:0]       c;
  logic             is_quote, is_brace, is_delim, is_dash, is_x, is_bs;
  logic             can_append, is_skip, has_tok, zx, perr;

  walk_ctl_t        walk_ctl;
  walk_sts_t        walk_sts;
  logic [CNT_W-1:0] walk_base;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic             push_valid;
  logic [7:0]       push_byte;
  logic             push_ready;
  logic             we;

  logic             req_valid;
  emit_req_t        req;
  logic             req_ready;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Classify the lowercased character
  always_comb begin
    if ((in_data_i.ch >= CH_UP_A) && (in_data_i.ch <= CH_UP_Z)) begin
      c = in_data_i.ch + CASE_OFFSET;
    end else begin
      c = in_data_i.ch;
    end
    is_quote   = (c == CH_QUOTE) || (c == CH_APOS);
    is_brace   = (c == CH_LBRACE) || (c == CH_RBRACE);
    is_delim   = (c == CH_CR) || (c == CH_LF) || (c == CH_BS) || (c == CH_TAB) ||
                 (c == CH_SPACE) || (c == CH_COMMA);
    is_dash    = (c == CH_DASH);
    is_x       = (c == CH_X);
    is_bs      = (c == CH_BSLASH);
    can_append = is_hex(c) || is_dash || is_x || (in_quote_q && is_bs);
    is_skip    = (c == CH_SEMI) && !in_braces_q && !in_quote_q;
  end

  // Plain flush check from the token summary
  always_comb begin
    has_tok = (count_q != '0);
    zx      = (count_q > CNT_W'(2)) && flags_q.c0_zero && flags_q.c1_x;
    if (zx) begin
      perr = flags_q.x_from2 || flags_q.dash_from2;
    end else begin
      perr = flags_q.x_any ||
             (flags_q.c0_dash && ((count_q == CNT_W'(1)) || flags_q.dash_from1));
    end
  end

  // Summary after appending the current character
  always_comb begin
    if (count_q == '0) begin
      flags_next = '{c0_zero: (c == CH_ZERO), c0_dash: is_dash, c1_x: 1'b0,
                     x_any: is_x, x_from2: 1'b0, dash_from1: 1'b0, dash_from2: 1'b0};
    end else begin
      flags_next            = flags_q;
      flags_next.c1_x       = (count_q == CNT_W'(1)) ? is_x : flags_q.c1_x;
      flags_next.x_any      = flags_q.x_any || is_x;
      flags_next.x_from2    = flags_q.x_from2 || (is_x && (count_q >= CNT_W'(2)));
      flags_next.dash_from1 = flags_q.dash_from1 || is_dash;
      flags_next.dash_from2 = flags_q.dash_from2 || (is_dash && (count_q >= CNT_W'(2)));
    end
  end

  // Main control
  always_comb begin
    state_d     = state_q;
    in_quote_d  = in_quote_q;
    in_braces_d = in_braces_q;
    error_d     = error_q;
    end_d       = end_q;
    count_d     = count_q;
    flags_d     = flags_q;
    walk_ctl    = '0;
    walk_base   = zx ? ZX_BASE : '0;
    we          = 1'b0;
    req_valid   = 1'b0;
    req         = '{op: OP_BYTE, value: push_byte, failed: error_q};
    push_ready  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.is_end) begin
            // end of text: final flush, then status
            end_d   = 1'b1;
            count_d = '0;
            state_d = S_STATUS;
            if (!error_q) begin
              if (in_quote_q) begin
                error_d = 1'b1;
              end else if (has_tok) begin
                if (perr) begin
                  error_d = 1'b1;
                end else begin
                  walk_ctl.start = 1'b1;
                  state_d        = S_WALK;
                end
              end
            end
          end else if (!error_q) begin
            end_d = 1'b0;
            priority if (is_quote) begin
              in_quote_d = !in_quote_q;
              count_d    = '0;
              if (has_tok) begin
                if (in_quote_q) begin
                  walk_ctl.start  = 1'b1;
                  walk_ctl.quoted = 1'b1;
                  walk_base       = '0;
                  state_d         = S_WALK;
                end else if (perr) begin
                  error_d = 1'b1;
                end else begin
                  walk_ctl.start = 1'b1;
                  state_d        = S_WALK;
                end
              end
            end else if (is_brace) begin
              in_braces_d = (c == CH_LBRACE);
            end else if (is_delim && !in_quote_q) begin
              count_d = '0;
              if (has_tok) begin
                if (perr) begin
                  error_d = 1'b1;
                end else begin
                  walk_ctl.start = 1'b1;
                  state_d        = S_WALK;
                end
              end
            end else if (can_append) begin
              if (count_q >= CNT_FULL) begin
                // overflow: flag and drop the token
                error_d = 1'b1;
                count_d = '0;
              end else begin
                we      = 1'b1;
                count_d = count_q + CNT_W'(1);
                flags_d = flags_next;
              end
            end else if (is_skip) begin
              // drop the separator
              count_d = count_q;
            end else begin
              error_d = 1'b1;
              count_d = '0;
            end
          end
        end
      end

      S_WALK: begin
        req_valid  = push_valid;
        push_ready = req_ready;
        if (walk_sts.done) begin
          if (walk_sts.failed) begin
            error_d = 1'b1;
          end
          state_d = end_q ? S_STATUS : S_CLOSE;
        end
      end

      S_CLOSE: begin
        req_valid = 1'b1;
        req.op    = OP_CLOSE;
        if (req_ready) begin
          state_d = S_IDLE;
        end
      end

      S_STATUS: begin
        req_valid = 1'b1;
        req.op    = OP_STATUS;
        if (req_ready) begin
          // return to the reset state
          in_quote_d  = 1'b0;
          in_braces_d = 1'b0;
          error_d     = 1'b0;
          end_d       = 1'b0;
          count_d     = '0;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_quote_q  <= 1'b0;
      in_braces_q <= 1'b0;
      error_q     <= 1'b0;
      end_q       <= 1'b0;
      count_q     <= '0;
      flags_q     <= '0;
    end else begin
      state_q     <= state_d;
      in_quote_q  <= in_quote_d;
      in_braces_q <= in_braces_d;
      error_q     <= error_d;
      end_q       <= end_d;
      count_q     <= count_d;
      flags_q     <= flags_d;
    end
  end

  // Token store
  hexp_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TOKEN_MAX)
  ) u_tok_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (c),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Flush walker
  hexp_walk #(
    .TOKEN_MAX (TOKEN_MAX)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (walk_ctl),
    .base_i       (walk_base),
    .len_i        (count_q),
    .sts_o        (walk_sts),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .push_valid_o (push_valid),
    .push_byte_o  (push_byte),
    .push_ready_i (push_ready)
  );

  // Result emitter and output register
  hexp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/hex_text_to_bytes_parser_top_tb.sv
// Self-checking testbench of the hex text parser: directed table, random texts, byte scoreboard.
`timescale 1ns / 1ps

module hex_text_to_bytes_parser_top_tb;
  import hexp_pkg::*;

  localparam int unsigned TOK_DEPTH   = TOKEN_MAX_DEF;
  localparam int          RAND_ITEMS  = 445;
  localparam int          CALM_ITEMS  = 60;
  localparam int          SETTLE_CYC  = 200;
  localparam int          CYCLE_LIMIT = 2_000_000;

  typedef struct {
    hexp_in_t  req;
    bit        typed;
    hexp_out_t want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  hexp_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  hexp_out_t out_data_o;

  // Parser state mirrored for prediction
  logic [7:0]  tok_mem [TOK_DEPTH];
  int unsigned tok_len;
  bit          quote_open;
  bit          brace_open;
  bit          text_bad;

  hexp_out_t bytes_now[$];
  hexp_out_t bytes_due[$];
  hexp_in_t  text_q[$];
  dir_row_t  dir_rows[$];

  int  sent       = 0;
  int  total_reqs = 0;
  int  mismatches = 0;
  int  cycles     = 0;
  int  stall_left = 0;
  bit  calm       = 1'b0;
  bit  idle_on    = 1'b1;

  hex_text_to_bytes_parser_top #(
    .TOKEN_MAX(TOK_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int hex_weight(logic [7:0] c);
    return ((int'(c) % 32) + 9) % 25;
  endfunction

  function automatic bit hex_digit(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LO_A && c <= CH_LO_F);
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    return c == CH_CR || c == CH_LF || c == CH_BS || c == CH_TAB ||
           c == CH_SPACE || c == CH_COMMA;
  endfunction

  function automatic void emit_byte(int v);
    bytes_now.push_back('{byte_value: v[7:0], is_status: 1'b0, parse_failed: 1'b0,
                          last: 1'b0});
  endfunction

  // Pad an odd run with a leading zero, then pack digit pairs
  function automatic void emit_pairs(logic [7:0] s[$]);
    int i;
    i = 0;
    if (s.size() % 2 == 1) begin
      emit_byte(hex_weight(s[0]));
      i = 1;
    end
    for (; i + 1 < s.size(); i += 2) begin
      emit_byte(hex_weight(s[i]) * 16 + hex_weight(s[i + 1]));
    end
  endfunction

  function automatic bit tok_has(int unsigned from, logic [7:0] c);
    for (int unsigned i = from; i < tok_len; i++) begin
      if (tok_mem[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void flush_bare();
    logic [7:0] s[$];
    if (tok_len > 2 && tok_mem[0] == CH_ZERO && tok_mem[1] == CH_X) begin
      if (tok_has(2, CH_X) || tok_has(2, CH_DASH)) begin
        text_bad = 1'b1;
      end else begin
        for (int unsigned i = 2; i < tok_len; i++) s.push_back(tok_mem[i]);
        emit_pairs(s);
      end
    end else if (tok_has(0, CH_X)) begin
      text_bad = 1'b1;
    end else if (tok_mem[0] == CH_DASH && (tok_len == 1 || tok_has(1, CH_DASH))) begin
      text_bad = 1'b1;
    end else begin
      for (int unsigned i = 0; i < tok_len; i++) s.push_back(tok_mem[i]);
      emit_pairs(s);
    end
    tok_len = 0;
  endfunction

  // Walk \xN / \xNN groups; bytes before a bad group still go out
  function automatic void flush_escaped();
    int unsigned i;
    bit          bad;
    logic [7:0]  c;
    logic [7:0]  dig[$];
    i   = 0;
    bad = 1'b0;
    while (i < tok_len) begin
      if (i + 2 >= tok_len) break;
      if (tok_mem[i] != CH_BSLASH || tok_mem[i + 1] != CH_X) begin
        bad = 1'b1;
        break;
      end
      i += 2;
      while (i < tok_len) begin
        c = tok_mem[i];
        if (!hex_digit(c)) begin
          if (c == CH_BSLASH) begin
            emit_pairs(dig);
            dig.delete();
          end else begin
            bad = 1'b1;
          end
          break;
        end
        dig.push_back(c);
        i++;
        if (dig.size() == 2) begin
          emit_pairs(dig);
          dig.delete();
          break;
        end
      end
      if (bad) break;
    end
    if (bad) begin
      text_bad = 1'b1;
    end else if (dig.size() > 0) begin
      emit_pairs(dig);
    end
    tok_len = 0;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) c = c + CASE_OFFSET;
    if (c == CH_QUOTE || c == CH_APOS) begin
      quote_open = !quote_open;
      if (tok_len > 0) begin
        if (quote_open) flush_bare();
        else flush_escaped();
      end
    end else if (c == CH_LBRACE || c == CH_RBRACE) begin
      brace_open = (c == CH_LBRACE);
    end else if (!quote_open && is_delim(c)) begin
      if (tok_len > 0) flush_bare();
    end else if (hex_digit(c) || c == CH_DASH || c == CH_X ||
                 (quote_open && c == CH_BSLASH)) begin
      if (tok_len >= TOK_DEPTH) begin
        text_bad = 1'b1;
        tok_len  = 0;
      end else begin
        tok_mem[tok_len] = c;
        tok_len++;
      end
    end else if (!(c == CH_SEMI && !brace_open && !quote_open)) begin
      text_bad = 1'b1;
      tok_len  = 0;
    end
  endfunction

  // Bytes and status that one request yields, in order, last one tagged
  function automatic void decode_request(hexp_in_t req);
    bytes_now.delete();
    if (req.is_end) begin
      if (!text_bad) begin
        if (quote_open) text_bad = 1'b1;
        else if (tok_len > 0) flush_bare();
      end
      bytes_now.push_back('{byte_value: 8'h00, is_status: 1'b1, parse_failed: text_bad,
                            last: 1'b0});
      quote_open = 1'b0;
      brace_open = 1'b0;
      text_bad   = 1'b0;
      tok_len    = 0;
    end else if (!text_bad) begin
      parse_char(req.ch);
    end
    if (bytes_now.size() > 0) bytes_now[bytes_now.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void add_row(logic [7:0] ch, bit is_end, bit typed = 1'b0,
                                  hexp_out_t want = '0);
    dir_rows.push_back('{req: '{ch: ch, is_end: is_end}, typed: typed, want: want});
  endfunction

  function automatic void put(logic [7:0] c);
    text_q.push_back('{ch: c, is_end: 1'b0});
  endfunction

  function automatic logic [7:0] rand_hex_ch();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_ZERO + 8'(v);
    return CH_LO_A + 8'(v - 10) - ($urandom_range(0, 1) ? CASE_OFFSET : 8'd0);
  endfunction

  function automatic logic [7:0] rand_delim();
    case ($urandom_range(0, 5))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_BS;
      3: return CH_TAB;
      4: return CH_SPACE;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] rand_quote();
    return $urandom_range(0, 1) ? CH_QUOTE : CH_APOS;
  endfunction

  function automatic logic [7:0] rand_x();
    return $urandom_range(0, 1) ? CH_X : CH_X - CASE_OFFSET;
  endfunction

  function automatic void put_hex_run(int n);
    repeat (n) put(rand_hex_ch());
  endfunction

  // Build one text: mostly well-formed tokens, some broken ones, then its end
  function automatic void build_text(int doc_no);
    int n_tok;
    int kind;
    text_q.delete();
    if (doc_no == 3) begin
      // full token flushed by the end: the longest burst of bytes
      put_hex_run(TOK_DEPTH);
    end else if (doc_no == 8) begin
      put_hex_run(TOK_DEPTH + 1);
      put(rand_delim());
    end else begin
      n_tok = $urandom_range(1, 6);
      for (int t = 0; t < n_tok; t++) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          if ($urandom_range(0, 3) == 0) begin
            put(CH_ZERO);
            put(rand_x());
          end else if ($urandom_range(0, 9) == 0) begin
            put(CH_DASH);
          end
          put_hex_run($urandom_range(1, 8));
          // sometimes run straight into the next token or the end
          if ($urandom_range(0, 9) != 0) put(rand_delim());
        end else if (kind < 75) begin
          put(rand_quote());
          repeat ($urandom_range(1, 4)) begin
            put(CH_BSLASH);
            put(rand_x());
            put_hex_run($urandom_range(0, 2));
          end
          if ($urandom_range(0, 15) != 0) put(rand_quote());
        end else if (kind < 83) begin
          put(CH_LBRACE);
          put_hex_run($urandom_range(0, 2));
          if ($urandom_range(0, 4) == 0) put(CH_SEMI);
          put(rand_delim());
          put(CH_RBRACE);
          put(CH_SEMI);
        end else begin
          case ($urandom_range(0, 5))
            0: put(8'($urandom_range(0, 255)));
            1: begin
              put_hex_run($urandom_range(1, 3));
              put(CH_X);
              put_hex_run($urandom_range(0, 2));
              put(rand_delim());
            end
            2: begin
              put(CH_DASH);
              put(rand_delim());
            end
            3: begin
              put(CH_DASH);
              put_hex_run($urandom_range(1, 2));
              put(CH_DASH);
              put(rand_delim());
            end
            4: begin
              put(CH_ZERO);
              put(CH_X);
              put_hex_run(1);
              put(CH_DASH);
              put(rand_delim());
            end
            default: begin
              put(rand_quote());
              put_hex_run($urandom_range(1, 3));
              put(rand_quote());
            end
          endcase
        end
      end
    end
    text_q.push_back('{ch: 8'($urandom_range(0, 255)), is_end: 1'b1});
  endfunction

  // Offer one request, hold it until taken, then record what it should yield
  task automatic send_req(hexp_in_t req, bit typed, hexp_out_t want);
    int gap;
    if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_request(req);
    if (typed) bytes_due.push_back(want);
    else foreach (bytes_now[i]) bytes_due.push_back(bytes_now[i]);
    sent++;
    calm = (sent >= total_reqs - CALM_ITEMS);
  endtask

  // Hold off new requests until every pending byte has drained
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (bytes_due.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    hexp_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bytes_due.size() == 0) begin
        $error("unexpected result %h with nothing pending", out_data_o);
        mismatches++;
      end else begin
        want = bytes_due.pop_front();
        if (out_data_o.byte_value !== want.byte_value) begin
          $error("byte_value: expected %02h, got %02h", want.byte_value,
                 out_data_o.byte_value);
          mismatches++;
        end
        if (out_data_o.is_status !== want.is_status) begin
          $error("is_status: expected %0d, got %0d", want.is_status, out_data_o.is_status);
          mismatches++;
        end
        if (out_data_o.parse_failed !== want.parse_failed) begin
          $error("parse_failed: expected %0d, got %0d", want.parse_failed,
                 out_data_o.parse_failed);
          mismatches++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data_o.last);
          mismatches++;
        end
      end
    end
    // Stall in random bursts, never in the closing stretch
    if (stall_left == 0 && idle_on && !calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14);
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int doc_no;
    quote_open = 1'b0;
    brace_open = 1'b0;
    text_bad   = 1'b0;
    tok_len    = 0;

    // end right after reset, ch ignored
    add_row(8'hFF, 1'b1, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1});
    // uppercase pair flushed by a comma
    add_row("A", 1'b0);
    add_row("B", 1'b0);
    add_row(CH_COMMA, 1'b0, 1'b1, {8'hAB, 1'b0, 1'b0, 1'b1});
    // 0x prefix with an odd digit count
    add_row(CH_ZERO, 1'b0);
    add_row(CH_X, 1'b0);
    add_row("f", 1'b0);
    add_row(CH_SPACE, 1'b0, 1'b1, {8'h0F, 1'b0, 1'b0, 1'b1});
    // leading dash decoded like a digit
    add_row(CH_DASH, 1'b0);
    add_row("1", 1'b0);
    add_row(CH_TAB, 1'b0);
    // semicolon skipped outside braces, then braces open and close
    add_row(CH_SEMI, 1'b0);
    add_row(CH_LBRACE, 1'b0);
    add_row(CH_RBRACE, 1'b0);
    // quoted escapes: a full group and a short one at the tail
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_BSLASH, 1'b0);
    add_row(CH_X, 1'b0);
    add_row("4", 1'b0);
    add_row("1", 1'b0);
    add_row(CH_BSLASH, 1'b0);
    add_row(CH_X, 1'b0);
    add_row("7", 1'b0);
    add_row(CH_APOS, 1'b0);
    // NUL is an illegal character; the end reports the failure
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, {8'h00, 1'b1, 1'b1, 1'b1});

    total_reqs = dir_rows.size() + RAND_ITEMS;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
    drain_results();

    doc_no = 0;
    while (sent < total_reqs) begin
      idle_on = ($urandom_range(0, 3) != 0);
      build_text(doc_no);
      foreach (text_q[i]) send_req(text_q[i], 1'b0, '0);
      if (doc_no == 6) drain_results();
      doc_no++;
    end

    in_valid_i <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
